// ===== rtl/ple_pkg.sv =====
// Package for the positional list engine: operation and status codes.
// Used by all rtl files through scoped names.
package ple_pkg;
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_INS_HD  = 3'd1;
    localparam logic [2:0] OP_INS_TL  = 3'd2;
    localparam logic [2:0] OP_INS_POS = 3'd3;
    localparam logic [2:0] OP_REM_HD  = 3'd4;
    localparam logic [2:0] OP_REM_TL  = 3'd5;
    localparam logic [2:0] OP_REM_POS = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // memory port request from the sequencer
    typedef struct packed {
        logic re;
        logic we;
    } mem_ctl_t;
endpackage

// ===== rtl/ple_store.sv =====
// Element store: single-port-write, single-read synchronous RAM.
// Depends on ple_pkg for the control struct.
module ple_store #(
    parameter int DEPTH = 256,
    parameter int WORD_BITS = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  ple_pkg::mem_ctl_t    ctl,
    input  logic [AW-1:0]        raddr,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);
    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.we) mem[waddr] <= wdata;
        if (ctl.re) rdata <= mem[raddr];
    end
endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Positional list engine: bounded ordered list of signed words in one RAM.
// Clear, the unused kind and refused ops pass from decode straight to finish; inserts
// shift the words from the slot on one place up, removes read the removed word and
// shift the words after it one place down. One transaction in flight;
// s_ready stays low until the result is taken.
// Reset (aresetn low, synchronous) empties the list; RAM contents stay undefined.
module positional_list_engine_unit #(
    parameter int DEPTH = 256,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic signed [31:0] s_value,
    input  logic [8:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic signed [31:0] m_removed_value,
    output logic [8:0]  m_element_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_SHR, S_SHL, S_RDX, S_FIN} state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;   // current position in the shift
    logic [CW-1:0] stop_reg;  // target index
    logic [2:0] kind_reg;
    logic [8:0] pos_reg;
    logic [WORD_BITS-1:0] val_reg;
    logic pend_reg;           // a shift read was issued last cycle
    logic [AW-1:0] pwaddr_reg;
    logic [1:0] st_reg;
    logic [31:0] rem_reg;
    logic m_valid_reg;

    ple_pkg::mem_ctl_t ctl;
    logic [AW-1:0] raddr, waddr;
    logic [WORD_BITS-1:0] wdata, rdata;

    ple_store #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_store (
        .aclk(aclk), .ctl(ctl), .raddr(raddr), .waddr(waddr),
        .wdata(wdata), .rdata(rdata)
    );

    logic [63:0] val_ext;
    assign val_ext = {{32{s_value[31]}}, s_value};

    logic [31:0] rd_out;
    always_comb begin
        logic [63:0] t;
        t = {{(64-WORD_BITS){rdata[WORD_BITS-1]}}, rdata};
        rd_out = t[31:0];
    end

    logic full, pos_ok;
    assign full = (count_reg >= CW'(DEPTH));
    assign pos_ok = (pos_reg != 9'd0) && ({{(CW>9?CW-9:0){1'b0}}, pos_reg} <= count_reg);

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_status = st_reg;
    assign m_removed_value = rem_reg;
    assign m_element_count = 9'(count_reg);

    // shift-right: read idx-1 then write idx; shift-left: read idx+1, write idx
    always_comb begin
        ctl = '0;
        raddr = '0;
        waddr = pwaddr_reg;
        wdata = rdata;
        case (state_reg)
            S_SHR: begin
                if (idx_reg > stop_reg) begin
                    ctl.re = 1'b1;
                    raddr = AW'(idx_reg - CW'(1));
                end
                ctl.we = pend_reg;
            end
            S_SHL: begin
                if (idx_reg + CW'(1) < count_reg) begin
                    ctl.re = 1'b1;
                    raddr = AW'(idx_reg + CW'(1));
                end
                ctl.we = pend_reg;
            end
            S_RDX: begin
                ctl.re = 1'b1;
                raddr = AW'(stop_reg);
            end
            S_FIN: begin
                // insert: drop the new word in its slot, only if it was taken
                if ((kind_reg == ple_pkg::OP_INS_HD || kind_reg == ple_pkg::OP_INS_TL ||
                     kind_reg == ple_pkg::OP_INS_POS) && st_reg == ple_pkg::ST_OK) begin
                    ctl.we = 1'b1;
                    waddr = AW'(stop_reg);
                    wdata = val_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        kind_reg <= s_kind;
                        pos_reg <= s_position;
                        val_reg <= val_ext[WORD_BITS-1:0];
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    st_reg <= ple_pkg::ST_OK;
                    rem_reg <= '0;
                    pend_reg <= 1'b0;
                    idx_reg <= count_reg;
                    state_reg <= S_FIN;
                    case (kind_reg)
                        ple_pkg::OP_CLEAR: count_reg <= '0;
                        ple_pkg::OP_INS_HD, ple_pkg::OP_INS_TL: begin
                            if (full) st_reg <= ple_pkg::ST_FULL;
                            else begin
                                stop_reg <= (kind_reg == ple_pkg::OP_INS_HD) ? '0 : count_reg;
                                state_reg <= S_SHR;
                            end
                        end
                        ple_pkg::OP_INS_POS: begin
                            if (!pos_ok) st_reg <= ple_pkg::ST_BADPOS;
                            else if (full) st_reg <= ple_pkg::ST_FULL;
                            else begin
                                stop_reg <= CW'(pos_reg) - CW'(1);
                                state_reg <= S_SHR;
                            end
                        end
                        ple_pkg::OP_REM_HD, ple_pkg::OP_REM_TL: begin
                            if (count_reg == '0) st_reg <= ple_pkg::ST_EMPTY;
                            else begin
                                stop_reg <= (kind_reg == ple_pkg::OP_REM_HD) ? '0
                                            : count_reg - CW'(1);
                                state_reg <= S_RDX;
                            end
                        end
                        ple_pkg::OP_REM_POS: begin
                            if (!pos_ok) st_reg <= ple_pkg::ST_BADPOS;
                            else begin
                                stop_reg <= CW'(pos_reg) - CW'(1);
                                state_reg <= S_RDX;
                            end
                        end
                        default: ;
                    endcase
                end
                S_RDX: begin
                    idx_reg <= stop_reg;
                    state_reg <= S_SHL;
                    pend_reg <= 1'b0;
                end
                S_SHR: begin
                    pend_reg <= (idx_reg > stop_reg);
                    pwaddr_reg <= AW'(idx_reg);
                    if (idx_reg > stop_reg) idx_reg <= idx_reg - CW'(1);
                    else if (!pend_reg || ctl.we) begin
                        state_reg <= S_FIN;
                        count_reg <= count_reg + CW'(1);
                    end
                end
                S_SHL: begin
                    // first cycle here: rdata holds the removed word
                    if (idx_reg == stop_reg && !pend_reg) rem_reg <= rd_out;
                    pend_reg <= (idx_reg + CW'(1) < count_reg);
                    pwaddr_reg <= AW'(idx_reg);
                    if (idx_reg + CW'(1) < count_reg) idx_reg <= idx_reg + CW'(1);
                    else begin
                        state_reg <= S_FIN;
                        count_reg <= count_reg - CW'(1);
                    end
                end
                S_FIN: begin
                    m_valid_reg <= 1'b1;
                    pend_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");
    a_fin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) |=> m_valid)
        else $error("result not raised after finish");
endmodule
